// ===== rtl/core/dtf_pkg.sv =====
// ============================================================================
// dtf_pkg - shared types and constants for the decimal text parser
// Holds the parse phase encoding, status codes, character codes and the
// power-of-ten function that fills the table used to pad the fraction.
// ============================================================================
package dtf_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned FRAC_W  = 5;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned POW_N   = 1 << FRAC_W;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_INT   = 3'd1,
        PH_FRAC  = 3'd2,
        PH_TRAIL = 3'd3
    } t_phase;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BLANK   = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

    // Character codes.
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    // Everything the scaler needs to finish one string.
    typedef struct packed {
        logic [VALUE_W-1:0] accum;
        logic               negative;
        logic [FRAC_W-1:0]  pad;
        logic [ST_W-1:0]    status;
    } t_term;

    // Ten to the k, modulo two to the value width.
    function automatic logic [VALUE_W-1:0] f_pow10(int unsigned k);
        logic [VALUE_W-1:0] p;
        p = VALUE_W'(1);
        for (int unsigned i = 0; i < k; i++) begin
            p = (p << 3) + (p << 1);
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/dtf_parse.sv =====
// ============================================================================
// dtf_parse - character parser
// Walks the text one character per cycle while i_take is high, keeps the running
// value and flags, and hands a finished string to the scaler at the terminator.
// ============================================================================
module dtf_parse import dtf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [CH_W-1:0]   i_ch,
    input  logic [FRAC_W-1:0] i_frac_digits,
    output logic              o_term_valid,
    output t_term             o_term
);

    t_phase             r_phase,      n_phase;
    logic [VALUE_W-1:0] r_accum,      n_accum;
    logic               r_negative,   n_negative;
    logic [FRAC_W-1:0]  r_frac_count, n_frac_count;
    logic               r_digit_seen, n_digit_seen;
    logic               r_error_seen, n_error_seen;

    logic               w_blank;
    logic               w_digit;
    logic               w_skip;
    t_phase             w_phase_eff;
    logic [VALUE_W-1:0] w_accum_digit;

    assign w_blank = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
    assign w_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    // A digit's value is its low nibble.
    assign w_accum_digit = (r_accum << 3) + (r_accum << 1)
                         + {{(VALUE_W-4){1'b0}}, i_ch[3:0]};

    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_negative   = r_negative;
        n_frac_count = r_frac_count;
        n_digit_seen = r_digit_seen;
        n_error_seen = r_error_seen;
        w_skip       = 1'b0;
        w_phase_eff  = r_phase;

        if (i_take) begin
            if (i_ch == CH_NUL) begin
                n_phase      = PH_LEAD;
                n_accum      = '0;
                n_negative   = 1'b0;
                n_frac_count = '0;
                n_digit_seen = 1'b0;
                n_error_seen = 1'b0;
            end else if (!r_error_seen) begin
                if (r_phase == PH_LEAD) begin
                    if (w_blank) begin
                        w_skip = 1'b1;
                    end else begin
                        n_phase     = PH_INT;
                        w_phase_eff = PH_INT;
                        if (i_ch == CH_MINUS) begin
                            n_negative = 1'b1;
                            w_skip     = 1'b1;
                        end else if (i_ch == CH_PLUS) begin
                            w_skip = 1'b1;
                        end
                    end
                end
                if (!w_skip) begin
                    case (w_phase_eff)
                        PH_INT: begin
                            if (w_digit) begin
                                n_accum      = w_accum_digit;
                                n_digit_seen = 1'b1;
                            end else if (i_ch == CH_DOT) begin
                                n_phase = PH_FRAC;
                            end else if (w_blank && r_digit_seen) begin
                                n_phase = PH_TRAIL;
                            end else begin
                                n_error_seen = 1'b1;
                            end
                        end
                        PH_FRAC: begin
                            if (w_digit) begin
                                if (r_frac_count < i_frac_digits) begin
                                    n_accum      = w_accum_digit;
                                    n_frac_count = r_frac_count + FRAC_W'(1);
                                    n_digit_seen = 1'b1;
                                end else if (!r_digit_seen) begin
                                    n_error_seen = 1'b1;
                                end
                            end else if (w_blank && r_digit_seen) begin
                                n_phase = PH_TRAIL;
                            end else begin
                                n_error_seen = 1'b1;
                            end
                        end
                        default: begin
                            if (!w_blank) begin
                                n_error_seen = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_accum      <= '0;
            r_negative   <= 1'b0;
            r_frac_count <= '0;
            r_digit_seen <= 1'b0;
            r_error_seen <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_negative   <= n_negative;
            r_frac_count <= n_frac_count;
            r_digit_seen <= n_digit_seen;
            r_error_seen <= n_error_seen;
        end
    end

    // Summary of the string as it stands when the terminator arrives.
    logic w_ok;
    always_comb begin
        w_ok = 1'b0;
        if (r_error_seen) begin
            o_term.status = ST_INVALID;
        end else if (r_phase == PH_LEAD) begin
            o_term.status = ST_BLANK;
        end else if (!r_digit_seen) begin
            o_term.status = ST_INVALID;
        end else begin
            o_term.status = ST_OK;
            w_ok          = 1'b1;
        end
        o_term.accum    = w_ok ? r_accum : '0;
        o_term.negative = w_ok && r_negative;
        o_term.pad      = (i_frac_digits > r_frac_count) ? (i_frac_digits - r_frac_count)
                                                         : '0;
    end

    assign o_term_valid = i_take && (i_ch == CH_NUL);

endmodule

// ===== rtl/core/dtf_scale.sv =====
// ============================================================================
// dtf_scale - fraction padding and sign pipeline
// Multiplies the parsed value by ten to the pad count, applies the sign and
// holds the result until the output side takes it.
// ============================================================================
module dtf_scale import dtf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_term               i_term,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VALUE_W-1:0]  o_value,
    output logic [ST_W-1:0]     o_status
);

    localparam int unsigned HALF_W = VALUE_W / 2;

    // Constant power-of-ten table, one entry per pad count.
    logic [VALUE_W-1:0] w_pow10 [POW_N];

    // Stage 1: operands.
    logic               r_v1;
    logic [VALUE_W-1:0] r_a1, r_b1;
    logic               r_neg1;
    logic [ST_W-1:0]    r_st1;
    // Stage 2: partial products.
    logic               r_v2;
    logic [VALUE_W-1:0] r_pll2;
    logic [HALF_W-1:0]  r_plh2, r_phl2;
    logic               r_neg2;
    logic [ST_W-1:0]    r_st2;
    // Stage 3: product.
    logic               r_v3;
    logic [VALUE_W-1:0] r_prod3;
    logic               r_neg3;
    logic [ST_W-1:0]    r_st3;
    // Stage 4: result.
    logic               r_v4;
    logic [VALUE_W-1:0] r_value4;
    logic [ST_W-1:0]    r_st4;

    logic w_adv1, w_adv2, w_adv3, w_adv4;
    logic [VALUE_W-1:0] w_pll;
    logic [HALF_W-1:0]  w_plh, w_phl;

    for (genvar k = 0; k < POW_N; k++) begin : g_pow10
        assign w_pow10[k] = f_pow10(k);
    end

    assign w_adv4 = !r_v4 || !i_stall;
    assign w_adv3 = !r_v3 || w_adv4;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;

    assign w_pll = {{HALF_W{1'b0}}, r_a1[HALF_W-1:0]} * {{HALF_W{1'b0}}, r_b1[HALF_W-1:0]};
    assign w_plh = r_a1[HALF_W-1:0] * r_b1[VALUE_W-1:HALF_W];
    assign w_phl = r_a1[VALUE_W-1:HALF_W] * r_b1[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_a1   <= i_term.accum;
            r_b1   <= w_pow10[i_term.pad];
            r_neg1 <= i_term.negative;
            r_st1  <= i_term.status;
        end
        if (w_adv2) begin
            r_pll2 <= w_pll;
            r_plh2 <= w_plh;
            r_phl2 <= w_phl;
            r_neg2 <= r_neg1;
            r_st2  <= r_st1;
        end
        if (w_adv3) begin
            r_prod3 <= r_pll2 + {r_plh2 + r_phl2, {HALF_W{1'b0}}};
            r_neg3  <= r_neg2;
            r_st3   <= r_st2;
        end
        if (w_adv4) begin
            r_value4 <= r_neg3 ? (VALUE_W'(0) - r_prod3) : r_prod3;
            r_st4    <= r_st3;
        end
    end

    assign o_ready  = w_adv1;
    assign o_valid  = r_v4;
    assign o_value  = r_value4;
    assign o_status = r_st4;

endmodule

// ===== rtl/core/decimal_text_to_fixed_point_core.sv =====
// ============================================================================
// decimal_text_to_fixed_point_core - ASCII decimal text to fixed point
// Parses a zero-terminated decimal string, one character per item, into a
// signed value scaled by ten to the configured number of fraction digits.
// ============================================================================
// Throughput: one character item per cycle while o_stall is low, terminators included.
// Results: a finished string passes the four-stage padding multiplier (products of
//   32-bit halves) through its operand, partial product, product and result registers.
// Reset (synchronous, active low) returns the parser to leading white space,
//   clears the pipeline valids and sets the fraction digit count to zero.
// ============================================================================
module decimal_text_to_fixed_point_core import dtf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: number of fraction digits.
    input  logic                       i_cfg_we,
    input  logic [FRAC_W-1:0]          i_cfg_data,
    // Character input.
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [CH_W-1:0]            i_ch,
    // Result output.
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic [ST_W-1:0]            o_status
);

    // The fraction digit count is read afresh on every character, so a
    // change between strings, or even within one, takes effect at once.
    logic [FRAC_W-1:0] r_frac_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_digits <= '0;
        end else if (i_cfg_we) begin
            r_frac_digits <= i_cfg_data;
        end
    end

    // The input side stalls only when the scaler pipeline is full and its
    // output is held back; ordinary characters never wait otherwise.
    logic              w_scale_ready;
    logic              w_take;
    logic              w_term_valid;
    t_term             w_term;
    logic [VALUE_W-1:0] w_value;

    assign o_stall = !w_scale_ready;
    assign w_take  = i_valid && !o_stall;

    // The parser updates its state in the cycle a character is accepted and,
    // for a terminator, presents the finished string and clears itself so the
    // next string may begin on the very next cycle.
    dtf_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_ch          (i_ch),
        .i_frac_digits (r_frac_digits),
        .o_term_valid  (w_term_valid),
        .o_term        (w_term)
    );

    // The scaler pads the missing fraction digits with one multiply by a
    // tabled power of ten, applies the sign and keeps the result in an
    // output register, with every stage free to fill while the output waits.
    dtf_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_term_valid),
        .i_term   (w_term),
        .o_ready  (w_scale_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_value  (w_value),
        .o_status (o_status)
    );

    assign o_value = signed'(w_value);

endmodule
